FILE: sv/sbd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the stereo bit crusher.
// No dependencies; used by the channel interfaces and the top level.
package sbd_pkg;

	// Sample format, Q1.23
	localparam int SAMPLE_BITS = 24;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	localparam logic signed [31:0] SAMPLE_MAX = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
	localparam logic signed [31:0] SAMPLE_MIN = -SAMPLE_MAX - 32'sd1;

	// Q0.16 unity
	localparam logic [16:0] Q16_ONE = 17'd65536;

	// 64-bit LCG multiplier, split into 32-bit halves
	localparam logic [31:0] LCG_MUL_LO = 32'h4C957F2D;
	localparam logic [31:0] LCG_MUL_HI = 32'h5851F42D;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;
	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_BIT_DEPTH = 3'd0;
	localparam cfg_index_t REG_CAPTURE_RATE = 3'd1;
	localparam cfg_index_t REG_NOISE_AMOUNT = 3'd2;
	localparam cfg_index_t REG_FILTER_AMOUNT = 3'd3;
	localparam cfg_index_t REG_SMOOTHING = 3'd4;
	localparam cfg_index_t REG_DRY_COEF = 3'd5;
	localparam cfg_index_t REG_WET_COEF = 3'd6;
	localparam cfg_index_t REG_NOISE_SEED = 3'd7;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LCG0,
		ST_LCG1,
		ST_LCG2,
		ST_LCG3,
		ST_NMUL,
		ST_NADD,
		ST_QUANT,
		ST_DIFF,
		ST_SMUL,
		ST_SADD,
		ST_WMUL,
		ST_WADD,
		ST_OMUL,
		ST_OADD,
		ST_ORND
	} state_t;

	// Clamp a signed value to the sample range
	function automatic sample_t sat_sample(input logic signed [31:0] v);
		logic signed [31:0] r;
		r = v;
		if (v > SAMPLE_MAX) r = SAMPLE_MAX;
		if (v < SAMPLE_MIN) r = SAMPLE_MIN;
		return SAMPLE_BITS'(r);
	endfunction

	// Q0.16 amounts above unity act as unity
	function automatic logic [16:0] sat_q16(input logic [16:0] v);
		return (v > Q16_ONE) ? Q16_ONE : v;
	endfunction

endpackage

FILE: sv/sbd_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: stereo input frame and processed result.
// Depends on sbd_pkg for the sample type.
interface sbd_frame_if;
	logic valid;
	logic ready;
	sbd_pkg::sample_t left_in;
	sbd_pkg::sample_t right_in;

	modport source(output valid, output left_in, output right_in, input ready);
	modport sink(input valid, input left_in, input right_in, output ready);
endinterface

interface sbd_result_if;
	logic valid;
	logic ready;
	sbd_pkg::sample_t left_out;
	sbd_pkg::sample_t right_out;
	logic captured;

	modport source(output valid, output left_out, output right_out, output captured,
		input ready);
	modport sink(input valid, input left_out, input right_out, input captured,
		output ready);
endinterface

FILE: sv/stereo_bitcrusher_downsampler.sv
`timescale 1ns / 1ps
// Stereo bit crusher / sample-rate reducer built around one shared 33x33 multiplier.
// Depends on sbd_pkg and the channel interfaces in sbd_ifs.sv.
//
//  channel  | dir | payload                          | transfer when
//  ---------+-----+----------------------------------+-------------------------
//  frame    | in  | left_in, right_in (Q1.23)        | frame.valid & frame.ready
//  result   | out | left_out, right_out, captured    | result.valid & result.ready
//  cfg      | in  | cfg_index, cfg_data              | cfg_we
//
// Each channel runs in turn through DIFF, SMUL, SADD, WMUL, WADD, OMUL, OADD and ORND,
// preceded on a capturing frame by the LCG and quantizer states (LCG0-LCG3, NMUL, NADD, QUANT);
// the single multiplier sets this order, every product goes through it in turn.
// The result sits in an output register, so the next frame is taken while it waits;
// if it is still untaken when the next result is ready, the sequencer holds.
// Reset (arst_n low) loads the register defaults, zeroes noise, phase, held
// and smoothed state and arms the first-frame capture.
module stereo_bitcrusher_downsampler #(
	parameter int SAMPLE_RATE = 48000
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sbd_frame_if.sink                      frame,
	sbd_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [sbd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int PW = $clog2(SAMPLE_RATE + 1);
	localparam int PW1 = PW + 1;
	localparam int SB = sbd_pkg::SAMPLE_BITS;

	// Configuration registers
	logic [4:0]         bd_q;
	logic [15:0]        rate_q;
	logic [16:0]        namt_q;
	logic [16:0]        filt_q;
	logic [16:0]        coef_q;
	logic signed [19:0] dry_q;
	logic signed [19:0] wetc_q;

	// Control state
	sbd_pkg::state_t state_q, state_d;
	logic            ch_q;
	logic            cap_q;
	logic            first_q;
	logic [PW-1:0]   phase_q;
	logic            res_valid_q;

	// Channel state
	logic [63:0]        ns_q;
	sbd_pkg::sample_t   held_q [2];
	logic signed [31:0] s_q [2];

	// Working registers
	sbd_pkg::sample_t   x_q [2];
	logic [31:0]        t_hi_q, t_lo_q;
	logic signed [65:0] p_q;
	sbd_pkg::sample_t   a_q;
	logic signed [32:0] d_q;
	logic signed [31:0] wet_q;
	logic signed [52:0] acc_q;
	sbd_pkg::sample_t   yl_q;
	sbd_pkg::sample_t   res_left_q, res_right_q;
	logic               res_cap_q;

	// Handshake and control
	logic accept, load_res;
	logic cap_now;
	logic [PW-1:0] phase_next;
	logic [PW-1:0] rate_sat;
	logic [PW:0]   psum;
	logic          wrap;

	// Datapath nets
	sbd_pkg::sample_t   x_cur, held_cur;
	logic signed [31:0] s_cur, h_cur, xs_cur;
	logic signed [32:0] mul_a, mul_b;
	logic               pneg;
	logic signed [51:0] nadd_v;
	logic signed [26:0] nadd_sum;
	logic [4:0]         qbits, qsh;
	logic [24:0]        qlow, qhalf;
	logic               qneg;
	logic signed [24:0] qv, qr;
	logic signed [51:0] sadd_v, sdif_v, wadd_v;
	logic signed [52:0] ornd_v;
	logic signed [28:0] y_rnd;
	sbd_pkg::sample_t   y_sat;

	assign frame.ready = (state_q == sbd_pkg::ST_IDLE);
	assign accept = frame.valid && frame.ready;

	assign result.valid = res_valid_q;
	assign result.left_out = res_left_q;
	assign result.right_out = res_right_q;
	assign result.captured = res_cap_q;

	assign x_cur = x_q[ch_q];
	assign held_cur = held_q[ch_q];
	assign s_cur = s_q[ch_q];
	assign h_cur = {held_cur, 8'b0};
	assign xs_cur = {x_cur, 8'b0};
	assign pneg = p_q[65];

	// Capture phase accumulator
	always_comb begin
		rate_sat = (32'(rate_q) > SAMPLE_RATE) ? PW'(SAMPLE_RATE) : PW'(rate_q);
		psum = PW1'(phase_q) + PW1'(rate_sat);
		wrap = (psum >= PW1'(SAMPLE_RATE));
		phase_next = wrap ? PW'(psum - PW1'(SAMPLE_RATE)) : PW'(psum);
		cap_now = first_q || wrap;
	end

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			sbd_pkg::ST_LCG0: begin
				mul_a = {1'b0, ns_q[31:0]};
				mul_b = {1'b0, sbd_pkg::LCG_MUL_LO};
			end
			sbd_pkg::ST_LCG1: begin
				mul_a = {1'b0, ns_q[63:32]};
				mul_b = {1'b0, sbd_pkg::LCG_MUL_LO};
			end
			sbd_pkg::ST_LCG2: begin
				mul_a = {1'b0, ns_q[31:0]};
				mul_b = {1'b0, sbd_pkg::LCG_MUL_HI};
			end
			sbd_pkg::ST_NMUL: begin
				// noise is 2r+1-2^32, which as 33-bit two's complement is {1, r, 1}
				mul_a = 33'(sbd_pkg::sat_q16(namt_q));
				mul_b = {1'b1, ns_q[63:33], 1'b1};
			end
			sbd_pkg::ST_DIFF: begin
				mul_a = 33'(dry_q);
				mul_b = 33'(xs_cur);
			end
			sbd_pkg::ST_SMUL: begin
				mul_a = 33'(sbd_pkg::sat_q16(coef_q));
				mul_b = d_q;
			end
			sbd_pkg::ST_WMUL: begin
				mul_a = 33'(sbd_pkg::sat_q16(filt_q));
				mul_b = d_q;
			end
			sbd_pkg::ST_OMUL: begin
				mul_a = 33'(wetc_q);
				mul_b = 33'(wet_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Rounding adders; half away from zero is floor(v + half - sign)
	always_comb begin
		// input plus scaled noise, rounded by 2^25
		nadd_v = p_q[51:0] + 52'sd16777216 - 52'(pneg) + (52'(x_cur) <<< 25);
		nadd_sum = nadd_v[51:25];

		// quantizer: round to a multiple of 2^qsh by clearing the low bits
		qbits = (bd_q == 5'd0) ? 5'd1 : bd_q;
		qsh = (qbits >= 5'(SB)) ? 5'd0 : 5'(5'(SB) - qbits);
		qlow = (25'd1 << qsh) - 25'd1;
		qhalf = qlow & ~(qlow >> 1);
		qneg = a_q[SB-1] && (qsh != 5'd0);
		qv = 25'(a_q) + qhalf - 25'(qneg);
		qr = qv & ~qlow;

		// smoother step, and the new difference smoothed - held alongside it
		sadd_v = p_q[51:0] + 52'sd32768 - 52'(pneg) + (52'(s_cur) <<< 16);
		sdif_v = p_q[51:0] + 52'sd32768 - 52'(pneg) - (52'(d_q) <<< 16);

		// held plus filtered blend
		wadd_v = p_q[51:0] + 52'sd32768 - 52'(pneg) + (52'(h_cur) <<< 16);

		// output scaling by 2^24
		ornd_v = acc_q + 53'sd8388608 - 53'(acc_q[52]);
		y_rnd = ornd_v[52:24];
		y_sat = sbd_pkg::sat_sample(32'(y_rnd));
	end

	// Sequencer: next state and strobes
	always_comb begin
		state_d = state_q;
		load_res = 1'b0;
		case (state_q)
			sbd_pkg::ST_IDLE: begin
				if (frame.valid) state_d = cap_now ? sbd_pkg::ST_LCG0 : sbd_pkg::ST_DIFF;
			end
			sbd_pkg::ST_LCG0: state_d = sbd_pkg::ST_LCG1;
			sbd_pkg::ST_LCG1: state_d = sbd_pkg::ST_LCG2;
			sbd_pkg::ST_LCG2: state_d = sbd_pkg::ST_LCG3;
			sbd_pkg::ST_LCG3: state_d = sbd_pkg::ST_NMUL;
			sbd_pkg::ST_NMUL: state_d = sbd_pkg::ST_NADD;
			sbd_pkg::ST_NADD: state_d = sbd_pkg::ST_QUANT;
			sbd_pkg::ST_QUANT: state_d = sbd_pkg::ST_DIFF;
			sbd_pkg::ST_DIFF: state_d = sbd_pkg::ST_SMUL;
			sbd_pkg::ST_SMUL: state_d = sbd_pkg::ST_SADD;
			sbd_pkg::ST_SADD: state_d = sbd_pkg::ST_WMUL;
			sbd_pkg::ST_WMUL: state_d = sbd_pkg::ST_WADD;
			sbd_pkg::ST_WADD: state_d = sbd_pkg::ST_OMUL;
			sbd_pkg::ST_OMUL: state_d = sbd_pkg::ST_OADD;
			sbd_pkg::ST_OADD: state_d = sbd_pkg::ST_ORND;
			sbd_pkg::ST_ORND: begin
				if (!ch_q) begin
					state_d = cap_q ? sbd_pkg::ST_LCG0 : sbd_pkg::ST_DIFF;
				end else if (!res_valid_q || result.ready) begin
					load_res = 1'b1;
					state_d = sbd_pkg::ST_IDLE;
				end
			end
			default: state_d = sbd_pkg::ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control, configuration and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bd_q <= 5'd24;
			rate_q <= 16'd48000;
			namt_q <= 17'd0;
			filt_q <= 17'd0;
			coef_q <= 17'd61800;
			dry_q <= 20'sd0;
			wetc_q <= 20'sd65536;
			ns_q <= '0;
			ch_q <= 1'b0;
			cap_q <= 1'b0;
			first_q <= 1'b1;
			phase_q <= '0;
			res_valid_q <= 1'b0;
			held_q[0] <= '0;
			held_q[1] <= '0;
			s_q[0] <= '0;
			s_q[1] <= '0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					sbd_pkg::REG_BIT_DEPTH: bd_q <= cfg_data[4:0];
					sbd_pkg::REG_CAPTURE_RATE: rate_q <= cfg_data[15:0];
					sbd_pkg::REG_NOISE_AMOUNT: namt_q <= cfg_data[16:0];
					sbd_pkg::REG_FILTER_AMOUNT: filt_q <= cfg_data[16:0];
					sbd_pkg::REG_SMOOTHING: coef_q <= cfg_data[16:0];
					sbd_pkg::REG_DRY_COEF: dry_q <= signed'(cfg_data[19:0]);
					sbd_pkg::REG_WET_COEF: wetc_q <= signed'(cfg_data[19:0]);
					sbd_pkg::REG_NOISE_SEED: ns_q <= {32'b0, cfg_data};
					default: ;
				endcase
			end

			// frame transfer: decide capture and advance the phase (not on the first frame)
			if (accept) begin
				ch_q <= 1'b0;
				cap_q <= cap_now;
				first_q <= 1'b0;
				if (!first_q) phase_q <= phase_next;
			end

			// LCG step completes
			if (state_q == sbd_pkg::ST_LCG3) ns_q <= {t_hi_q + p_q[31:0], t_lo_q};

			if (state_q == sbd_pkg::ST_QUANT) held_q[ch_q] <= sbd_pkg::sat_sample(32'(qr));
			if (state_q == sbd_pkg::ST_SADD) s_q[ch_q] <= sadd_v[47:16];

			if (state_q == sbd_pkg::ST_ORND && !ch_q) ch_q <= 1'b1;

			// output register
			if (result.valid && result.ready) res_valid_q <= 1'b0;
			if (load_res) res_valid_q <= 1'b1;
		end
	end

	// Datapath working registers
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		if (accept) begin
			x_q[0] <= frame.left_in;
			x_q[1] <= frame.right_in;
		end
		case (state_q)
			sbd_pkg::ST_LCG1: {t_hi_q, t_lo_q} <= p_q[63:0] + 64'd1;
			sbd_pkg::ST_LCG2: t_hi_q <= t_hi_q + p_q[31:0];
			sbd_pkg::ST_NADD: a_q <= sbd_pkg::sat_sample(32'(nadd_sum));
			sbd_pkg::ST_DIFF: d_q <= 33'(h_cur) - 33'(s_cur);
			sbd_pkg::ST_SMUL: acc_q <= p_q[52:0];
			sbd_pkg::ST_SADD: d_q <= sdif_v[48:16];
			sbd_pkg::ST_WADD: wet_q <= wadd_v[47:16];
			sbd_pkg::ST_OADD: acc_q <= acc_q + p_q[52:0];
			sbd_pkg::ST_ORND: begin
				if (!ch_q) yl_q <= y_sat;
			end
			default: ;
		endcase
		if (load_res) begin
			res_left_q <= yl_q;
			res_right_q <= y_sat;
			res_cap_q <= cap_q;
		end
	end

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !frame.ready)
		else $error("frame ready right after a transfer");

	a_first_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !first_q)
		else $error("first-frame flag survived a transfer");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < PW'(SAMPLE_RATE))
		else $error("capture phase out of range");

	a_lcg_on_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sbd_pkg::ST_LCG0) |-> cap_q)
		else $error("noise drawn on a frame without capture");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == sbd_pkg::ST_ORND && ch_q))
		else $error("result raised outside the final rounding step");

endmodule
